@@ src/bfi_pkg.sv @@
// ----------------------------------------------------------------------------
// bfi_pkg
// Shared widths, register indexes and types for the black frame insertion
// cadence block.
// ----------------------------------------------------------------------------
package bfi_pkg;

    // counter and timestamp widths
    localparam int COUNT_BITS = 32;
    localparam int TIME_BITS  = 32;

    // field widths
    localparam int SI_W     = 5;   // strobe interval, signed
    localparam int PERIOD_W = 16;  // swap period in ticks
    localparam int RTIME_W  = 32;  // refresh timestamp port
    localparam int MAG_W    = 5;   // |interval|, up to 16
    localparam int MOD_W    = 5;   // modulus and remainder, up to 17

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_STROBE_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_PERIOD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VSYNC_ON        = 2'd2;

    // status of the serial swap timer
    typedef struct packed {
        logic busy;
        logic lt_p;   // elapsed < period
        logic lt_2p;  // elapsed < 2 * period
    } t_swap_res;

endpackage

@@ src/bfi_mod_serial.sv @@
// ----------------------------------------------------------------------------
// bfi_mod_serial
// Bit-serial remainder: shifts the count out MSB first and folds each bit
// into a narrow running remainder, one bit per cycle.
// ----------------------------------------------------------------------------
module bfi_mod_serial (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bfi_pkg::COUNT_BITS-1:0] i_value,
    input  logic [bfi_pkg::MOD_W-1:0]   i_modulus,
    output logic                        o_busy,
    output logic [bfi_pkg::MOD_W-1:0]   o_rem
);
    import bfi_pkg::*;

    localparam int CNT_W = $clog2(COUNT_BITS);

    logic                  r_busy;
    logic [CNT_W-1:0]      r_k;
    logic [COUNT_BITS-1:0] r_sr;
    logic [MOD_W-1:0]      r_mod;
    logic [MOD_W-1:0]      r_rem;
    logic [MOD_W:0]        w_acc;
    logic [MOD_W-1:0]      n_rem;

    // r < m, so 2r + bit < 2m: one conditional subtract
    always_comb begin
        w_acc = {r_rem, r_sr[COUNT_BITS-1]};
        if (w_acc >= {1'b0, r_mod}) begin
            n_rem = MOD_W'(w_acc - {1'b0, r_mod});
        end else begin
            n_rem = w_acc[MOD_W-1:0];
        end
    end

    // shift control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_k    <= '0;
            r_sr   <= i_value;
            r_mod  <= i_modulus;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_sr  <= {r_sr[COUNT_BITS-2:0], 1'b0};
            r_rem <= n_rem;
            r_k   <= r_k + 1'b1;
            if (r_k == CNT_W'(COUNT_BITS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

    // running remainder always stays below the modulus
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_mod))
        else $error("remainder out of range");

endmodule

@@ src/bfi_swap_timer.sv @@
// ----------------------------------------------------------------------------
// bfi_swap_timer
// Bit-serial elapsed-time check: forms now - reference LSB first and
// compares it against the period and twice the period on the fly.
// ----------------------------------------------------------------------------
module bfi_swap_timer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bfi_pkg::TIME_BITS-1:0] i_now,
    input  logic [bfi_pkg::TIME_BITS-1:0] i_ref,
    input  logic [bfi_pkg::PERIOD_W-1:0]  i_period,
    output bfi_pkg::t_swap_res            o_res
);
    import bfi_pkg::*;

    localparam int CNT_W = $clog2(TIME_BITS);
    localparam int EXT_W = 65;

    logic                 r_busy;
    logic [CNT_W-1:0]     r_k;
    logic [TIME_BITS-1:0] r_now_sr;
    logic [TIME_BITS-1:0] r_ref_sr;
    logic [TIME_BITS-1:0] r_p_sr;
    logic [TIME_BITS-1:0] r_p2_sr;
    logic                 r_p2_ovf;
    logic                 r_borrow;
    logic                 r_lt_p;
    logic                 r_lt_2p;
    logic [EXT_W-1:0]     w_p_ext;
    logic [EXT_W-1:0]     w_p2_ext;
    logic                 w_n;
    logic                 w_r;
    logic                 w_d;
    logic                 n_borrow;

    assign w_p_ext  = {{(EXT_W-PERIOD_W){1'b0}}, i_period};
    assign w_p2_ext = w_p_ext << 1;

    // one bit of the serial subtract
    assign w_n      = r_now_sr[0];
    assign w_r      = r_ref_sr[0];
    assign w_d      = w_n ^ w_r ^ r_borrow;
    assign n_borrow = (~w_n & w_r) | (~(w_n ^ w_r) & r_borrow);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
        end else if (i_start) begin
            r_busy   <= 1'b1;
            r_k      <= '0;
            r_now_sr <= i_now;
            r_ref_sr <= i_ref;
            r_p_sr   <= w_p_ext[TIME_BITS-1:0];
            r_p2_sr  <= w_p2_ext[TIME_BITS-1:0];
            r_p2_ovf <= w_p2_ext[TIME_BITS];
            r_borrow <= 1'b0;
            r_lt_p   <= 1'b0;
            r_lt_2p  <= 1'b0;
        end else if (r_busy) begin
            r_now_sr <= r_now_sr >> 1;
            r_ref_sr <= r_ref_sr >> 1;
            r_p_sr   <= r_p_sr >> 1;
            r_p2_sr  <= r_p2_sr >> 1;
            r_borrow <= n_borrow;
            // higher bits override the verdict of lower ones
            if (w_d != r_p_sr[0]) begin
                r_lt_p <= r_p_sr[0];
            end
            if (w_d != r_p2_sr[0]) begin
                r_lt_2p <= r_p2_sr[0];
            end
            r_k <= r_k + 1'b1;
            if (r_k == CNT_W'(TIME_BITS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // twice the period past the timestamp width exceeds any elapsed time
    assign o_res.busy  = r_busy;
    assign o_res.lt_p  = r_lt_p;
    assign o_res.lt_2p = r_lt_2p | r_p2_ovf;

endmodule

@@ src/black_frame_insertion_cadence_top.sv @@
// ----------------------------------------------------------------------------
// Flow: one refresh at a time; a new refresh is accepted only once the result
//   of the last is in the output register. A strobed refresh also waits for
//   the bit-serial remainder and elapsed-time units to finish.
// Reset: synchronous active low; counters, swap flag and reference clear,
//   interval and period reset to 0, vsync to 1; no clearing pass.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// black_frame_insertion_cadence_top
// Decides per display refresh whether to show the rendered frame or a black
// frame, tracking phase counters and an optional phase swap timer.
// ----------------------------------------------------------------------------
module black_frame_insertion_cadence_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [bfi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bfi_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // refresh input
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [bfi_pkg::RTIME_W-1:0]    i_refresh_time,
    // decision output
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_show_frame,
    output logic                           o_positive_phase,
    output logic                           o_phase_swapped,
    output logic                           o_strobing_active
);
    import bfi_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic signed [SI_W-1:0] r_si;
    logic [PERIOD_W-1:0]    r_period;
    logic                   r_vsync;

    // cadence state
    logic [COUNT_BITS-1:0]  r_rc;
    logic [COUNT_BITS-1:0]  r_pc;
    logic [COUNT_BITS-1:0]  r_nc;
    logic                   r_flag;
    logic [TIME_BITS-1:0]   r_ref;
    logic signed [SI_W-1:0] r_last;

    // per-refresh context
    logic [TIME_BITS-1:0]   r_now;
    logic [MAG_W-1:0]       r_a;
    logic                   r_neg;
    logic                   r_pos;
    logic                   r_byp;

    // effective state after a possible clear
    logic                   w_acc;
    logic                   w_clr;
    logic [COUNT_BITS-1:0]  w_rc;
    logic [COUNT_BITS-1:0]  w_pc;
    logic [COUNT_BITS-1:0]  w_nc;
    logic                   w_flag;
    logic [TIME_BITS-1:0]   w_ref;
    logic                   w_byp;
    logic                   w_pos;
    logic [MAG_W-1:0]       w_a;
    logic [MOD_W-1:0]       w_mod;
    logic [63:0]            w_time_ext;
    logic [TIME_BITS-1:0]   w_now;

    logic                   w_mod_busy;
    logic [MOD_W-1:0]       w_rem;
    t_swap_res              w_swap;
    logic                   w_swap_en;
    logic                   w_units_done;
    logic                   w_same;
    logic                   w_render;
    logic                   w_slot_free;

    assign w_acc      = i_in_valid && o_in_ready;
    assign w_time_ext = {{(64-RTIME_W){1'b0}}, i_refresh_time};
    assign w_now      = w_time_ext[TIME_BITS-1:0];

    // clear on interval change or saturated refresh count
    assign w_clr  = ((r_last != '0) && (r_last != r_si)) || (&r_rc);
    assign w_rc   = w_clr ? '0 : r_rc;
    assign w_pc   = w_clr ? '0 : r_pc;
    assign w_nc   = w_clr ? '0 : r_nc;
    assign w_flag = w_clr ? 1'b0 : r_flag;
    assign w_ref  = w_clr ? '0 : r_ref;
    assign w_byp  = (r_si == '0) || !r_vsync;
    assign w_pos  = ~w_rc[0];

    // magnitude and modulus: a+1 for even intervals, (a+1)/2 for odd
    always_comb begin
        w_a = r_si[SI_W-1] ? MAG_W'(-r_si) : MAG_W'(r_si);
        if (w_a[0]) begin
            w_mod = MOD_W'((w_a + 1'b1) >> 1);
        end else begin
            w_mod = MOD_W'(w_a + 1'b1);
        end
    end

    // serial remainder of the pre-increment phase count
    bfi_mod_serial u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_acc && !w_byp),
        .i_value   (w_pos ? w_pc : w_nc),
        .i_modulus (w_mod),
        .o_busy    (w_mod_busy),
        .o_rem     (w_rem)
    );

    // serial elapsed-time check
    bfi_swap_timer u_swap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_acc && !w_byp),
        .i_now    (w_now),
        .i_ref    (w_ref),
        .i_period (r_period),
        .o_res    (w_swap)
    );

    assign w_units_done = !w_mod_busy && !w_swap.busy;
    assign w_swap_en    = (r_period != '0) && r_a[0];
    assign w_slot_free  = !o_out_valid || i_out_ready;

    // slot decision
    always_comb begin
        w_same = (r_pos == r_flag);
        if (!r_a[0]) begin
            w_render = w_same ? (w_rem == MOD_W'(r_a >> 1)) : (w_rem == '0);
        end else begin
            w_render = w_same ? 1'b0 : (w_rem == '0);
        end
        w_render = w_render ^ r_neg;
    end

    // sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_si        <= '0;
            r_period    <= '0;
            r_vsync     <= 1'b1;
            r_rc        <= '0;
            r_pc        <= '0;
            r_nc        <= '0;
            r_flag      <= 1'b0;
            r_ref       <= '0;
            r_last      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready && (r_state != S_DONE)) begin
                o_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_STROBE_INTERVAL: r_si     <= i_cfg_data[SI_W-1:0];
                    CFG_SWAP_PERIOD:     r_period <= i_cfg_data[PERIOD_W-1:0];
                    CFG_VSYNC_ON:        r_vsync  <= i_cfg_data[0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_last <= r_si;
                        r_now  <= w_now;
                        r_a    <= w_a;
                        r_neg  <= r_si[SI_W-1];
                        r_pos  <= w_pos;
                        r_byp  <= w_byp;
                        r_flag <= w_flag;
                        r_ref  <= w_ref;
                        if (w_byp) begin
                            r_rc <= '0;
                            r_pc <= w_pc;
                            r_nc <= w_nc;
                            // vsync off forces the interval back to zero
                            if ((r_si != '0) &&
                                !(i_cfg_we && (i_cfg_index == CFG_STROBE_INTERVAL))) begin
                                r_si <= '0;
                            end
                            r_state <= S_DONE;
                        end else begin
                            r_rc <= w_rc + 1'b1;
                            r_pc <= w_pos ? w_pc + 1'b1 : w_pc;
                            r_nc <= w_pos ? w_nc : w_nc + 1'b1;
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (w_units_done) begin
                        // swap timer update for odd intervals with a nonzero swap period
                        if (w_swap_en) begin
                            if (!w_swap.lt_p && w_swap.lt_2p) begin
                                r_flag <= 1'b1;
                            end else if (w_swap.lt_p) begin
                                r_flag <= 1'b0;
                            end else begin
                                r_ref <= r_now;
                            end
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_slot_free) begin
                        o_out_valid       <= 1'b1;
                        o_show_frame      <= r_byp ? 1'b1 : w_render;
                        o_positive_phase  <= r_byp ? 1'b0 : r_pos;
                        o_phase_swapped   <= r_flag;
                        o_strobing_active <= !r_byp;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // serial units are quiet whenever the block waits for a refresh
    a_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!w_mod_busy && !w_swap.busy))
        else $error("serial unit busy while idle");

    // a bypassed refresh leaves the refresh count at zero
    a_bypass_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_byp) |=> (r_rc == '0) && (r_state == S_DONE))
        else $error("bypass did not clear refresh count");

    // bypassed results always show the frame in no phase
    a_bypass_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_strobing_active) |-> (o_show_frame && !o_positive_phase))
        else $error("bypass result malformed");

endmodule
